FILE: hdl/ttl_lfu_cache_table_unit_macros.svh
// assertion macros for the cache table unit
`ifndef TTL_LFU_CACHE_TABLE_UNIT_MACROS_SVH
`define TTL_LFU_CACHE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, quiet in reset
`define TTL_LFU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cache table check failed");

// next-cycle implication, checked on clk, quiet in reset
`define TTL_LFU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cache table check failed");

`endif

FILE: hdl/ttl_lfu_pkg.sv
`default_nettype none
package ttl_lfu_pkg;

	// request codes
	localparam logic [2:0] REQ_LOOKUP = 3'd0;
	localparam logic [2:0] REQ_INSERT = 3'd1;
	localparam logic [2:0] REQ_SWEEP  = 3'd2;
	localparam logic [2:0] REQ_TICK   = 3'd3;
	localparam logic [2:0] REQ_CLEAR  = 3'd4;

	// register indexes and reset values
	localparam logic REG_TTL = 1'b0;
	localparam logic REG_CAP = 1'b1;
	localparam logic [15:0] TTL_RESET = 16'd300;
	localparam logic [10:0] CAP_RESET = 11'd1024;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [63:0] key_tag;
		logic [31:0] payload_in;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] payload_out;
		logic [10:0] evicted_now;
		logic [10:0] occupancy;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] evict_total;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic [31:0] payload;
		logic [31:0] expiry;
		logic [31:0] uses;
		logic [31:0] stamp;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_SWEEP,
		ST_VICTIM,
		ST_DROP,
		ST_FIND,
		ST_UPDATE
	} state_t;

	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		return (v == SAT32) ? v : v + 32'd1;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/ttl_lfu_cache_table_unit.sv
// cache table with expiry and least-used eviction, one item at a time
// tick and unused codes: result in the cycle after accept; lookup: find pass, update
// sweep: a sweep pass; clear: a clearing pass; insert: sweep pass when full, victim
// pass and drop if still full, then find pass and update; passes walk the whole memory
// reset: busy while a clearing pass writes every entry invalid
// results are strobed on done for one cycle; the receiver cannot stall
`default_nettype none
`include "ttl_lfu_cache_table_unit_macros.svh"
module ttl_lfu_cache_table_unit #(
	parameter int ENTRIES = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire ttl_lfu_pkg::req_t   req,
	output logic                     done,
	output ttl_lfu_pkg::rsp_t        rsp,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready
);

	localparam int AW    = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CW    = (CNT_W > 11) ? CNT_W : 11;
	localparam int EW    = $bits(ttl_lfu_pkg::entry_t);
	localparam logic [AW:0] DEPTH = (AW+1)'(ENTRIES);
	localparam logic [AW:0] LAST  = (AW+1)'(ENTRIES - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(ENTRIES);

	ttl_lfu_pkg::state_t state_q, state_d;
	ttl_lfu_pkg::req_t   req_q;
	ttl_lfu_pkg::entry_t rentry, wentry, ent_q;
	logic [EW-1:0] rdata;

	logic          item_q, done_q;
	logic [AW:0]   rd_addr_q;
	logic          pend_s1;
	logic [AW-1:0] addr_s1;
	logic [CW-1:0] cnt_q, removed_q, limit;
	logic          found_q, free_q, best_q;
	logic [AW-1:0] found_idx_q, free_idx_q, best_idx_q;
	logic [63:0]   best_key_q;
	logic [31:0]   stamp_q, time_q, stamp_ctr_q, hits_q, misses_q, evict_q;
	logic [15:0]   ttl_q;
	logic [10:0]   cap_q;
	logic          hit_q;
	logic [31:0]   pay_q;

	logic          accept, issue, scan_end, proc, expired, key_eq, lk_hit;
	logic          we, re;
	logic [AW-1:0] waddr;
	logic [32:0]   exp_sum;
	logic [31:0]   exp_sat;

	assign accept   = start && !busy;
	assign busy     = (state_q != ttl_lfu_pkg::ST_IDLE);
	assign issue    = (rd_addr_q < DEPTH);
	assign scan_end = !issue && !pend_s1;
	assign rentry   = ttl_lfu_pkg::entry_t'(rdata);
	assign proc     = pend_s1 && rentry.valid;
	assign expired  = (time_q >= rentry.expiry);
	assign key_eq   = (rentry.key == req_q.key_tag);
	assign lk_hit   = found_q && (time_q < ent_q.expiry);
	assign exp_sum  = {1'b0, time_q} + {17'd0, ttl_q};
	assign exp_sat  = exp_sum[32] ? ttl_lfu_pkg::SAT32 : exp_sum[31:0];

	// effective capacity: zero acts as one, clipped to the table size
	always_comb begin
		priority if (cap_q == 11'd0) begin
			limit = CW'(1);
		end else if (CW'(cap_q) > DEPTH_C) begin
			limit = DEPTH_C;
		end else begin
			limit = CW'(cap_q);
		end
	end

	// entry memory
	ttl_lfu_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (EW'(wentry)),
		.re    (re),
		.raddr (rd_addr_q[AW-1:0]),
		.rdata (rdata)
	);

	// next state and memory port control
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		re      = 1'b0;
		waddr   = addr_s1;
		wentry  = rentry;
		unique case (state_q)
			ttl_lfu_pkg::ST_CLR: begin
				we     = 1'b1;
				waddr  = rd_addr_q[AW-1:0];
				wentry = '0;
				if (rd_addr_q == LAST) begin
					state_d = ttl_lfu_pkg::ST_IDLE;
				end
			end
			ttl_lfu_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						ttl_lfu_pkg::REQ_LOOKUP: state_d = ttl_lfu_pkg::ST_FIND;
						ttl_lfu_pkg::REQ_INSERT: begin
							state_d = (cnt_q >= limit) ? ttl_lfu_pkg::ST_SWEEP
								: ttl_lfu_pkg::ST_FIND;
						end
						ttl_lfu_pkg::REQ_SWEEP: state_d = ttl_lfu_pkg::ST_SWEEP;
						ttl_lfu_pkg::REQ_CLEAR: state_d = ttl_lfu_pkg::ST_CLR;
						default: state_d = ttl_lfu_pkg::ST_IDLE;
					endcase
				end
			end
			ttl_lfu_pkg::ST_SWEEP: begin
				re = issue;
				if (proc && expired) begin
					we           = 1'b1;
					wentry.valid = 1'b0;
				end
				if (scan_end) begin
					if (req_q.req_type != ttl_lfu_pkg::REQ_INSERT) begin
						state_d = ttl_lfu_pkg::ST_IDLE;
					end else if (cnt_q >= limit) begin
						state_d = ttl_lfu_pkg::ST_VICTIM;
					end else begin
						state_d = ttl_lfu_pkg::ST_FIND;
					end
				end
			end
			ttl_lfu_pkg::ST_VICTIM: begin
				re = issue;
				if (scan_end) begin
					state_d = best_q ? ttl_lfu_pkg::ST_DROP : ttl_lfu_pkg::ST_FIND;
				end
			end
			ttl_lfu_pkg::ST_DROP: begin
				we      = 1'b1;
				waddr   = best_idx_q;
				wentry  = '0;
				state_d = ttl_lfu_pkg::ST_FIND;
			end
			ttl_lfu_pkg::ST_FIND: begin
				re = issue;
				if (scan_end) begin
					state_d = ttl_lfu_pkg::ST_UPDATE;
				end
			end
			ttl_lfu_pkg::ST_UPDATE: begin
				state_d = ttl_lfu_pkg::ST_IDLE;
				if (req_q.req_type == ttl_lfu_pkg::REQ_LOOKUP) begin
					we     = lk_hit;
					waddr  = found_idx_q;
					wentry = '{valid: 1'b1, key: req_q.key_tag, payload: ent_q.payload,
						expiry: ent_q.expiry, uses: ttl_lfu_pkg::sat_inc32(ent_q.uses),
						stamp: stamp_ctr_q};
				end else begin
					we     = found_q || free_q;
					waddr  = found_q ? found_idx_q : free_idx_q;
					wentry = '{valid: 1'b1, key: req_q.key_tag, payload: req_q.payload_in,
						expiry: exp_sat, uses: 32'd1, stamp: stamp_q};
				end
			end
			default: state_d = ttl_lfu_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttl_lfu_pkg::ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// scan address and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			pend_s1   <= 1'b0;
		end else if (state_d != state_q) begin
			rd_addr_q <= '0;
			pend_s1   <= 1'b0;
		end else if (state_q == ttl_lfu_pkg::ST_CLR) begin
			rd_addr_q <= rd_addr_q + (AW+1)'(1);
		end else begin
			pend_s1   <= re;
			rd_addr_q <= rd_addr_q + (AW+1)'(re);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr_q[AW-1:0];
	end

	// item control, counters and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q      <= 1'b0;
			done_q      <= 1'b0;
			cnt_q       <= '0;
			removed_q   <= '0;
			time_q      <= '0;
			stamp_ctr_q <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evict_q     <= '0;
			hit_q       <= 1'b0;
			pay_q       <= '0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			best_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				item_q    <= 1'b1;
				hit_q     <= 1'b0;
				pay_q     <= '0;
				removed_q <= '0;
				found_q   <= 1'b0;
				free_q    <= 1'b0;
				if (req.req_type == ttl_lfu_pkg::REQ_INSERT) begin
					stamp_ctr_q <= ttl_lfu_pkg::sat_inc32(stamp_ctr_q);
				end
				if (req.req_type == ttl_lfu_pkg::REQ_CLEAR) begin
					removed_q <= cnt_q;
					cnt_q     <= '0;
				end
				if (req.req_type == ttl_lfu_pkg::REQ_TICK) begin
					time_q <= ttl_lfu_pkg::sat_inc32(time_q);
				end
				if (state_d == ttl_lfu_pkg::ST_IDLE) begin
					done_q <= 1'b1;
				end
			end
			// clearing pass end: report only when a clear item started it
			if (state_q == ttl_lfu_pkg::ST_CLR && state_d == ttl_lfu_pkg::ST_IDLE) begin
				done_q <= item_q;
			end
			// sweep drops
			if (state_q == ttl_lfu_pkg::ST_SWEEP) begin
				if (proc && expired) begin
					cnt_q     <= cnt_q - CW'(1);
					removed_q <= removed_q + CW'(1);
					evict_q   <= ttl_lfu_pkg::sat_inc32(evict_q);
				end
				if (state_d == ttl_lfu_pkg::ST_IDLE) begin
					done_q <= 1'b1;
				end
			end
			// victim search
			if (state_d == ttl_lfu_pkg::ST_VICTIM && state_q != ttl_lfu_pkg::ST_VICTIM) begin
				best_q <= 1'b0;
			end
			if (state_q == ttl_lfu_pkg::ST_VICTIM && proc &&
				(!best_q || {rentry.uses, rentry.stamp} < best_key_q)) begin
				best_q <= 1'b1;
			end
			if (state_q == ttl_lfu_pkg::ST_DROP) begin
				cnt_q     <= cnt_q - CW'(1);
				removed_q <= removed_q + CW'(1);
				evict_q   <= ttl_lfu_pkg::sat_inc32(evict_q);
			end
			// key and free slot search
			if (state_q == ttl_lfu_pkg::ST_FIND) begin
				if (proc && key_eq) begin
					found_q <= 1'b1;
				end
				if (pend_s1 && !rentry.valid) begin
					free_q <= 1'b1;
				end
			end
			// write back and result
			if (state_q == ttl_lfu_pkg::ST_UPDATE) begin
				done_q <= 1'b1;
				if (req_q.req_type == ttl_lfu_pkg::REQ_LOOKUP) begin
					if (lk_hit) begin
						hit_q       <= 1'b1;
						pay_q       <= ent_q.payload;
						hits_q      <= ttl_lfu_pkg::sat_inc32(hits_q);
						stamp_ctr_q <= ttl_lfu_pkg::sat_inc32(stamp_ctr_q);
					end else begin
						misses_q <= ttl_lfu_pkg::sat_inc32(misses_q);
					end
				end else if (!found_q && free_q) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// payload captures, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req;
			stamp_q <= stamp_ctr_q;
		end
		if (state_q == ttl_lfu_pkg::ST_VICTIM && proc &&
			(!best_q || {rentry.uses, rentry.stamp} < best_key_q)) begin
			best_idx_q <= addr_s1;
			best_key_q <= {rentry.uses, rentry.stamp};
		end
		if (state_q == ttl_lfu_pkg::ST_FIND) begin
			if (proc && key_eq && !found_q) begin
				found_idx_q <= addr_s1;
				ent_q       <= rentry;
			end
			if (pend_s1 && !rentry.valid && !free_q) begin
				free_idx_q <= addr_s1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= ttl_lfu_pkg::TTL_RESET;
			cap_q <= ttl_lfu_pkg::CAP_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				ttl_lfu_pkg::REG_TTL: ttl_q <= pwdata[15:0];
				ttl_lfu_pkg::REG_CAP: cap_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ttl_lfu_pkg::REG_TTL: prdata = {16'd0, ttl_q};
			ttl_lfu_pkg::REG_CAP: prdata = {21'd0, cap_q};
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// result beat
	assign done             = done_q;
	assign rsp.hit          = hit_q;
	assign rsp.payload_out  = pay_q;
	assign rsp.evicted_now  = removed_q[10:0];
	assign rsp.occupancy    = cnt_q[10:0];
	assign rsp.hit_total    = hits_q;
	assign rsp.miss_total   = misses_q;
	assign rsp.evict_total  = evict_q;

	// checks
	`TTL_LFU_ASSERT_NEXT(a_accept_moves, accept, busy || done)
	`TTL_LFU_ASSERT_IMPL(a_write_busy, we, busy)
	`TTL_LFU_ASSERT_IMPL(a_occ_bound, done, cnt_q <= DEPTH_C)
	`TTL_LFU_ASSERT_IMPL(a_hit_lookup, done && hit_q, req_q.req_type == ttl_lfu_pkg::REQ_LOOKUP)

endmodule
`default_nettype wire

FILE: hdl/ttl_lfu_ram.sv
`default_nettype none
module ttl_lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: test/ttl_lfu_cache_table_checker.sv
`default_nettype none
module ttl_lfu_cache_table_checker #(
	parameter int ENTRIES = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire ttl_lfu_pkg::req_t  req,
	input  wire logic               done,
	input  wire ttl_lfu_pkg::rsp_t  rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic               pready,
	output int                      fail_count
);
	import ttl_lfu_pkg::*;

	localparam logic [31:0] TOP32 = 32'hFFFF_FFFF;

	// shadow copy of the table
	logic        tbl_valid [ENTRIES];
	logic [63:0] tbl_key [ENTRIES];
	logic [31:0] tbl_payload [ENTRIES];
	logic [31:0] tbl_expiry [ENTRIES];
	logic [31:0] tbl_uses [ENTRIES];
	logic [31:0] tbl_stamp [ENTRIES];
	logic [31:0] now_ticks, next_stamp, live_count;
	logic [31:0] hits, misses, evictions;
	logic [15:0] lifetime;
	logic [10:0] cap_reg;
	rsp_t        pending_rsp[$];

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == TOP32) ? v : v + 32'd1;
	endfunction

	// drop every expired entry, return how many went
	function automatic logic [31:0] purge_expired();
		logic [31:0] n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && now_ticks >= tbl_expiry[i]) begin
				tbl_valid[i] = 1'b0;
				if (live_count > 0) live_count--;
				evictions = bump(evictions);
				n++;
			end
		return n;
	endfunction

	// lowest index holding the key, or -1
	function automatic int locate(input logic [63:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && tbl_key[i] == k) return i;
		return -1;
	endfunction

	// insert with expiry sweep and least-used eviction
	function automatic logic [31:0] store_entry(input logic [63:0] k, input logic [31:0] p);
		logic [31:0] limit, removed, stamp;
		logic [32:0] sum;
		int          slot, victim;
		removed = 0;
		stamp = next_stamp;
		next_stamp = bump(next_stamp);
		limit = cap_reg;
		if (limit == 0) limit = 1;
		if (limit > ENTRIES) limit = ENTRIES;
		if (live_count >= limit) begin
			removed += purge_expired();
			if (live_count >= limit) begin
				victim = -1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (!tbl_valid[i]) continue;
					if (victim < 0 || tbl_uses[i] < tbl_uses[victim] ||
					    (tbl_uses[i] == tbl_uses[victim] && tbl_stamp[i] < tbl_stamp[victim]))
						victim = i;
				end
				if (victim >= 0) begin
					tbl_valid[victim] = 1'b0;
					if (live_count > 0) live_count--;
					evictions = bump(evictions);
					removed++;
				end
			end
		end
		slot = locate(k);
		if (slot < 0) begin
			for (int i = 0; i < ENTRIES; i++)
				if (!tbl_valid[i]) begin
					slot = i;
					break;
				end
			if (slot < 0) return removed;
			tbl_valid[slot] = 1'b1;
			live_count++;
		end
		sum = {1'b0, now_ticks} + {17'd0, lifetime};
		tbl_key[slot] = k;
		tbl_payload[slot] = p;
		tbl_expiry[slot] = sum[32] ? TOP32 : sum[31:0];
		tbl_uses[slot] = 32'd1;
		tbl_stamp[slot] = stamp;
		return removed;
	endfunction

	// expected result of one request beat
	function automatic rsp_t cache_predict(input req_t r);
		rsp_t        o;
		int          s;
		logic [31:0] removed;
		o = '0;
		removed = 0;
		case (r.req_type)
			REQ_LOOKUP: begin
				s = locate(r.key_tag);
				if (s >= 0 && now_ticks < tbl_expiry[s]) begin
					tbl_stamp[s] = next_stamp;
					next_stamp = bump(next_stamp);
					tbl_uses[s] = bump(tbl_uses[s]);
					hits = bump(hits);
					o.hit = 1'b1;
					o.payload_out = tbl_payload[s];
				end else begin
					misses = bump(misses);
				end
			end
			REQ_INSERT: removed = store_entry(r.key_tag, r.payload_in);
			REQ_SWEEP:  removed = purge_expired();
			REQ_TICK:   now_ticks = bump(now_ticks);
			REQ_CLEAR: begin
				removed = live_count;
				for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
				live_count = 0;
			end
			default: ;
		endcase
		o.evicted_now = removed[10:0];
		o.occupancy = live_count[10:0];
		o.hit_total = hits;
		o.miss_total = misses;
		o.evict_total = evictions;
		return o;
	endfunction

	task automatic check_field(input string fname, input logic [63:0] e, input logic [63:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, e, a);
			fail_count++;
		end
	endtask

	// result beats first, then config writes and request beats
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
			now_ticks = 0;
			next_stamp = 0;
			live_count = 0;
			hits = 0;
			misses = 0;
			evictions = 0;
			lifetime = TTL_RESET;
			cap_reg = CAP_RESET;
			pending_rsp.delete();
		end else begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual %0h", $time, rsp);
					fail_count++;
				end else begin
					want = pending_rsp.pop_front();
					check_field("hit", want.hit, rsp.hit);
					check_field("payload_out", want.payload_out, rsp.payload_out);
					check_field("evicted_now", want.evicted_now, rsp.evicted_now);
					check_field("occupancy", want.occupancy, rsp.occupancy);
					check_field("hit_total", want.hit_total, rsp.hit_total);
					check_field("miss_total", want.miss_total, rsp.miss_total);
					check_field("evict_total", want.evict_total, rsp.evict_total);
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == 3'(4 * REG_TTL)) lifetime = pwdata[15:0];
				else if (paddr == 3'(4 * REG_CAP)) cap_reg = pwdata[10:0];
			end
			if (start && !busy) pending_rsp.push_back(cache_predict(req));
		end
	end

	initial fail_count = 0;
endmodule
`default_nettype wire

FILE: test/tb_ttl_lfu_cache_table_unit.sv
`default_nettype none
module tb_ttl_lfu_cache_table_unit;
	import ttl_lfu_pkg::*;

	localparam int ENTRIES = 1024;
	localparam int SETTLE = 3 * ENTRIES + 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        done;
	rsp_t        rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          sent_count = 0;
	int          done_count = 0;
	logic [63:0] key_pool [12];
	bit          allow_gaps;

	always #2 clk = ~clk;

	ttl_lfu_cache_table_unit #(.ENTRIES(ENTRIES)) i_dut (
		.clk, .arst_n, .start, .busy, .req, .done, .rsp,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	ttl_lfu_cache_table_checker #(.ENTRIES(ENTRIES)) i_checker (
		.clk, .arst_n, .start, .busy, .req, .done, .rsp,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count
	);

	always @(posedge clk) begin
		if (done) done_count <= done_count + 1;
	end

	// one request beat, start stays high until the next gap
	task automatic send_req(input logic [2:0] kind, input logic [63:0] k, input logic [31:0] p);
		start <= 1'b1;
		req <= '{req_type: kind, key_tag: k, payload_in: p};
		do @(posedge clk); while (busy);
		sent_count++;
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// let every outstanding result arrive
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (done_count != sent_count || busy) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * idx);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [15:0] ttl, input logic [10:0] cap);
		drain();
		reg_write(REG_TTL, {16'd0, ttl});
		reg_write(REG_CAP, {21'd0, cap});
	endtask

	// mostly pooled keys so lookups hit and inserts collide
	task automatic random_items(input int n);
		int          pick;
		logic [2:0]  kind;
		logic [63:0] k;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 36) kind = REQ_LOOKUP;
			else if (pick < 72) kind = REQ_INSERT;
			else if (pick < 86) kind = REQ_TICK;
			else if (pick < 93) kind = REQ_SWEEP;
			else if (pick < 96) kind = REQ_CLEAR;
			else kind = 3'($urandom_range(5, 7));
			if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
			else k = key_pool[$urandom_range(0, 11)];
			send_req(kind, k, $urandom);
		end
	endtask

	initial begin
		logic [15:0] ttl_set [6];
		logic [10:0] cap_set [6];
		ttl_set = '{16'd1, 16'd3, 16'd65535, 16'd5, 16'd0, 16'd2};
		cap_set = '{11'd2, 11'd4, 11'd8, 11'd2047, 11'd3, 11'd1};
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 12; i++) key_pool[i] = {$urandom, $urandom};
		allow_gaps = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// directed: reset settings, every request code, field extremes
		configure(16'd300, 11'd1024);
		send_req(REQ_LOOKUP, '1, '0);
		send_req(REQ_INSERT, '1, '1);
		send_req(REQ_LOOKUP, '1, '0);
		send_req(REQ_INSERT, '0, 32'h0);
		send_req(REQ_LOOKUP, '0, '1);
		send_req(REQ_TICK, '0, '0);
		send_req(REQ_SWEEP, '0, '0);
		send_req(3'd5, '1, '1);
		send_req(3'd6, '0, '0);
		send_req(3'd7, '1, '1);
		send_req(REQ_CLEAR, '0, '0);
		// zero lifetime and capacity zero acting as one
		configure(16'd0, 11'd0);
		send_req(REQ_INSERT, key_pool[2], 32'h1234_5678);
		send_req(REQ_LOOKUP, key_pool[2], '0);
		send_req(REQ_INSERT, key_pool[2], 32'h8765_4321);
		send_req(REQ_INSERT, key_pool[3], 32'hA5A5_A5A5);
		// least-used eviction at a capacity of two entries
		configure(16'd100, 11'd2);
		send_req(REQ_INSERT, key_pool[4], 32'd4);
		send_req(REQ_INSERT, key_pool[5], 32'd5);
		send_req(REQ_LOOKUP, key_pool[4], '0);
		send_req(REQ_INSERT, key_pool[6], 32'd6);
		send_req(REQ_INSERT, key_pool[4], 32'd7);
		send_req(REQ_LOOKUP, key_pool[5], '0);
		send_req(REQ_CLEAR, '0, '0);

		// random phases across settings
		for (int ph = 0; ph < 6; ph++) begin
			configure(ttl_set[ph], cap_set[ph]);
			if (ph == 5) allow_gaps = 1'b0;
			random_items(44);
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && i_checker.pending_rsp.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
+incdir+hdl
hdl/ttl_lfu_pkg.sv
hdl/ttl_lfu_ram.sv
hdl/ttl_lfu_cache_table_unit.sv
test/ttl_lfu_cache_table_checker.sv
test/tb_ttl_lfu_cache_table_unit.sv
